// ----- rtl/working_day_counter_unit_defines.svh -----
// Assertion macros shared by the working-day counter RTL.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef WORKING_DAY_COUNTER_UNIT_DEFINES_SVH
`define WORKING_DAY_COUNTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define WDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define WDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WDC_ASSERT_IMP(lbl, ante, cons, msg)
`define WDC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/wdc_pkg.sv -----
// Shared types, constants and calendar functions for the working-day counter.
// No dependencies; used by wdc_recip_div and working_day_counter_unit.
package wdc_pkg;

  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [3:0]  MON_FEB      = 4'd2;
  localparam logic [3:0]  MON_DEC      = 4'd12;
  localparam logic [6:0]  CENTURY      = 7'd100;
  localparam logic [8:0]  QUAD_CENTURY = 9'd400;

  // Reciprocal constants: floor(x / 100) = (x * 5243) >> 19 for x < 16384,
  // floor(x / 7) = (x * 18725) >> 17 for x < 32768.
  localparam logic [14:0] RECIP_100 = 15'd5243;
  localparam int          SHIFT_100 = 19;
  localparam logic [14:0] RECIP_7   = 15'd18725;
  localparam int          SHIFT_7   = 17;
  localparam int          DIV_W     = 13;

  localparam logic [6:0]  WEEKEND_RESET = 7'd96;

  typedef enum logic [0:0] {
    DIV_BY_100 = 1'b0,
    DIV_BY_7   = 1'b1
  } div_sel_t;

  typedef struct packed {
    div_sel_t    sel;
    logic [14:0] operand;
  } div_req_t;

  function automatic logic is_leap(input logic [1:0] y_lo, input logic [6:0] r100,
                                   input logic [8:0] r400);
    is_leap = ((y_lo == 2'd0) && (r100 != 7'd0)) || (r400 == 9'd0);
  endfunction

  // Length of a month; zero for a month code outside January to December.
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days_in = 5'd30;
      4'd2:    days_in = leap ? 5'd29 : 5'd28;
      default: days_in = 5'd0;
    endcase
  endfunction

  // (31 * mm) / 12 with mm the March-based month number.
  function automatic logic [4:0] month_offset(input logic [3:0] month);
    case (month)
      4'd1:    month_offset = 5'd28;
      4'd2:    month_offset = 5'd31;
      4'd3:    month_offset = 5'd2;
      4'd4:    month_offset = 5'd5;
      4'd5:    month_offset = 5'd7;
      4'd6:    month_offset = 5'd10;
      4'd7:    month_offset = 5'd12;
      4'd8:    month_offset = 5'd15;
      4'd9:    month_offset = 5'd18;
      4'd10:   month_offset = 5'd20;
      4'd11:   month_offset = 5'd23;
      4'd12:   month_offset = 5'd25;
      default: month_offset = 5'd0;
    endcase
  endfunction

endpackage

// ----- rtl/wdc_recip_div.sv -----
// Shared constant divider: one multiplier by a reciprocal, registered quotient.
// Depends on wdc_pkg.
module wdc_recip_div (
  input  logic                          clk,
  input  wdc_pkg::div_req_t             req,
  output logic [wdc_pkg::DIV_W-1:0]     quot
);
  import wdc_pkg::*;

  logic [14:0]      recip;
  logic [29:0]      prod;
  logic [DIV_W-1:0] quot_nxt;
  logic [DIV_W-1:0] quot_r;

  always_comb begin
    recip = (req.sel == DIV_BY_100) ? RECIP_100 : RECIP_7;
    prod  = {15'd0, req.operand} * {15'd0, recip};
    case (req.sel)
      DIV_BY_100: quot_nxt = DIV_W'(prod >> SHIFT_100);
      DIV_BY_7:   quot_nxt = DIV_W'(prod >> SHIFT_7);
      default:    quot_nxt = DIV_W'(prod >> SHIFT_7);
    endcase
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
  end

  assign quot = quot_r;

endmodule

// ----- rtl/working_day_counter_unit.sv -----
// Top level of the working-day counter: handshakes, sequencer and day stepper.
// Depends on wdc_pkg, wdc_recip_div and working_day_counter_unit_defines.svh.
//
// Channel  Direction  Ports                          Contents
// in       slave      in_tvalid/in_tready/in_tdata   start and end date
// out      master     out_tvalid/out_tready/out_*    working-day count, status
// cfg      write      cfg_we/cfg_wdata               weekend mask
//
// An item with a valid start date is stepped one day per cycle, after a weekday setup
// that makes three passes through the one shared divider. An invalid start date goes
// straight to its result without stepping. in_tready is high only while idle, so no
// new item is taken until the last one is through; a finished item waits until the
// output register is free.
// Synchronous reset clears the sequencer and output valid; the mask reads Fri/Sat.
`include "working_day_counter_unit_defines.svh"

module working_day_counter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year, [27:23] end_day,
  // [31:28] end_month, [45:32] end_year, [47:46] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [21:0] working_days, [23:22] zero
  output logic [23:0] out_tdata,
  // [0] status
  output logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  import wdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_Q100, S_Q400, S_R400, S_CHK, S_Q7, S_MOD, S_STEP, S_DONE
  } state_t;

  state_t       state_r, state_nxt;
  logic [6:0]   mask_r, mask_nxt;
  logic [4:0]   sd_r, sd_nxt, ed_r, ed_nxt;
  logic [3:0]   sm_r, sm_nxt, em_r, em_nxt;
  logic [13:0]  sy_r, sy_nxt, ey_r, ey_nxt;
  logic [7:0]   q100_r, q100_nxt;
  logic [5:0]   q400_r, q400_nxt;
  logic [6:0]   r100_r, r100_nxt;
  logic [8:0]   r400_r, r400_nxt;
  logic [14:0]  sum_r, sum_nxt;
  logic [4:0]   cd_r, cd_nxt;
  logic [3:0]   cm_r, cm_nxt;
  logic [13:0]  cy_r, cy_nxt;
  logic [2:0]   wday_r, wday_nxt;
  logic [21:0]  cnt_r, cnt_nxt;
  logic         status_r, status_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [21:0]  out_cnt_r, out_cnt_nxt;
  logic         out_status_r, out_status_nxt;

  div_req_t         div_req;
  logic [DIV_W-1:0] quot;

  logic         jan_feb;
  logic [13:0]  yy;
  logic [14:0]  q100_adj, q400_adj;
  logic [14:0]  sum_w;
  logic [13:0]  r100_full, r400_full;
  logic [14:0]  wday_full;
  logic         start_ok;
  logic         cur_leap;
  logic [4:0]   cur_dim;
  logic         cur_before_end;

  wdc_recip_div u_div (
    .clk  (clk),
    .req  (div_req),
    .quot (quot)
  );

  // Weekday setup: January and February belong to the previous year.
  always_comb begin
    jan_feb   = (sm_r <= MON_FEB);
    yy        = sy_r - {13'd0, jan_feb};
    q100_adj  = {7'd0, q100_r} - 15'(jan_feb && (r100_r == 7'd0));
    q400_adj  = {9'd0, q400_r} - 15'(jan_feb && (r400_r == 9'd0));
    sum_w     = 15'(sd_r) + 15'(yy) + 15'(yy[13:2]) - q100_adj + q400_adj
                + 15'(month_offset(sm_r));
    r100_full = sy_r - 14'({6'd0, quot[7:0]} * 14'd100);
    r400_full = sy_r - 14'({8'd0, quot[5:0]} * 14'd400);
    wday_full = sum_r - 15'({2'd0, quot} * 15'd7);
    start_ok  = (sm_r >= 4'd1) && (sm_r <= MON_DEC) && (sy_r >= 14'd1)
                && (sy_r <= YEAR_MAX) && (sd_r >= 5'd1)
                && (sd_r <= days_in(sm_r, is_leap(sy_r[1:0], r100_r, r400_r)));
  end

  // Day stepper view of the current date.
  always_comb begin
    cur_leap       = is_leap(cy_r[1:0], r100_r, r400_r);
    cur_dim        = days_in(cm_r, cur_leap);
    cur_before_end = (cy_r < ey_r) || ((cy_r == ey_r) &&
                     ((cm_r < em_r) || ((cm_r == em_r) && (cd_r < ed_r))));
  end

  always_comb begin
    div_req.sel     = DIV_BY_100;
    div_req.operand = {1'b0, sy_r};
    case (state_r)
      S_Q400:  div_req.operand = {3'd0, sy_r[13:2]};
      S_Q7: begin
        div_req.sel     = DIV_BY_7;
        div_req.operand = sum_r;
      end
      default: div_req.operand = {1'b0, sy_r};
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    mask_nxt       = cfg_we ? cfg_wdata : mask_r;
    sd_nxt         = sd_r;
    sm_nxt         = sm_r;
    sy_nxt         = sy_r;
    ed_nxt         = ed_r;
    em_nxt         = em_r;
    ey_nxt         = ey_r;
    q100_nxt       = q100_r;
    q400_nxt       = q400_r;
    r100_nxt       = r100_r;
    r400_nxt       = r400_r;
    sum_nxt        = sum_r;
    cd_nxt         = cd_r;
    cm_nxt         = cm_r;
    cy_nxt         = cy_r;
    wday_nxt       = wday_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cnt_nxt    = out_cnt_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sd_nxt    = in_tdata[4:0];
          sm_nxt    = in_tdata[8:5];
          sy_nxt    = in_tdata[22:9];
          ed_nxt    = in_tdata[27:23];
          em_nxt    = in_tdata[31:28];
          ey_nxt    = in_tdata[45:32];
          state_nxt = S_Q100;
        end
      end
      S_Q100: state_nxt = S_Q400;
      S_Q400: begin
        q100_nxt  = quot[7:0];
        r100_nxt  = r100_full[6:0];
        state_nxt = S_R400;
      end
      S_R400: begin
        q400_nxt  = quot[5:0];
        r400_nxt  = r400_full[8:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        sum_nxt = sum_w;
        cd_nxt  = sd_r;
        cm_nxt  = sm_r;
        cy_nxt  = sy_r;
        cnt_nxt = 22'd0;
        if (start_ok) begin
          status_nxt = 1'b0;
          state_nxt  = S_Q7;
        end else begin
          status_nxt = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_Q7: state_nxt = S_MOD;
      S_MOD: begin
        wday_nxt  = wday_full[2:0];
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if ((cy_r > YEAR_MAX) || !cur_before_end) begin
          state_nxt = S_DONE;
        end else begin
          if (!mask_r[wday_r]) begin
            cnt_nxt = cnt_r + 22'd1;
          end
          wday_nxt = (wday_r == 3'd6) ? 3'd0 : wday_r + 3'd1;
          if (cd_r == cur_dim) begin
            cd_nxt = 5'd1;
            if (cm_r == MON_DEC) begin
              cm_nxt   = 4'd1;
              cy_nxt   = cy_r + 14'd1;
              r100_nxt = (r100_r == CENTURY - 7'd1) ? 7'd0 : r100_r + 7'd1;
              r400_nxt = (r400_r == QUAD_CENTURY - 9'd1) ? 9'd0 : r400_r + 9'd1;
            end else begin
              cm_nxt = cm_r + 4'd1;
            end
          end else begin
            cd_nxt = cd_r + 5'd1;
          end
        end
      end
      S_DONE: begin
        // Load the output register once the previous result has been taken.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_cnt_nxt    = cnt_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= WEEKEND_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sd_r         <= sd_nxt;
    sm_r         <= sm_nxt;
    sy_r         <= sy_nxt;
    ed_r         <= ed_nxt;
    em_r         <= em_nxt;
    ey_r         <= ey_nxt;
    q100_r       <= q100_nxt;
    q400_r       <= q400_nxt;
    r100_r       <= r100_nxt;
    r400_r       <= r400_nxt;
    sum_r        <= sum_nxt;
    cd_r         <= cd_nxt;
    cm_r         <= cm_nxt;
    cy_r         <= cy_nxt;
    wday_r       <= wday_nxt;
    cnt_r        <= cnt_nxt;
    status_r     <= status_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r};
  assign out_tuser  = out_status_r;

  `WDC_ASSERT_NXT(a_accept_starts_setup, in_tvalid && in_tready, state_r == S_Q100, "accepted item did not start the divider sequence")
  `WDC_ASSERT_NXT(a_bad_start_skips_loop, (state_r == S_CHK) && !start_ok, (state_r == S_DONE) && status_r, "invalid start date entered the day loop")
  `WDC_ASSERT_IMP(a_weekday_range, state_r == S_STEP, wday_r != 3'd7, "weekday out of range while stepping")
  `WDC_ASSERT_IMP(a_year_residues, state_r == S_STEP, (r100_r < CENTURY) && (r400_r < QUAD_CENTURY), "year residue counters out of range")
  `WDC_ASSERT_IMP(a_status_zero_count, out_valid_r && out_status_r, out_cnt_r == 22'd0, "invalid start date reported a nonzero count")

endmodule

// ----- tb/working_day_counter_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the working-day counter: watches the date, result and mask ports,
// predicts each count by walking the calendar and compares. Depends on wdc_pkg.
module working_day_counter_checker
  import wdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          awaited_count
);

  typedef struct packed {
    logic [1:0]  pad;
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
  } date_span_t;

  typedef struct packed {
    logic [21:0] working_days;
    logic        status;
  } day_tally_t;

  day_tally_t  awaited_tallies[$];
  logic [6:0]  weekend_mask_q;

  // Where the last walk stopped.
  logic [4:0]  walk_day;
  logic [3:0]  walk_month;
  logic [13:0] walk_year;
  int unsigned walk_weekday;

  function automatic logic [4:0] month_length(input logic [3:0] month, input logic [13:0] year);
    logic leap_year;
    leap_year = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    if (month == MON_FEB) begin
      return leap_year ? 5'd29 : 5'd28;
    end
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      default:                                    return 5'd0;
    endcase
  endfunction

  // January and February count as months 13 and 14 of the previous year.
  function automatic int unsigned weekday_of(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned jan_feb;
    int unsigned yy;
    int unsigned mm;
    jan_feb = (m <= 2) ? 1 : 0;
    yy = y - jan_feb;
    mm = m + 12 * jan_feb - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
  endfunction

  function automatic day_tally_t count_working_days(input date_span_t span);
    day_tally_t  tally;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    int unsigned wd;
    tally = '0;
    if (span.start_month < 1 || span.start_month > MON_DEC ||
        span.start_year < 1 || span.start_year > YEAR_MAX || span.start_day < 1 ||
        span.start_day > month_length(span.start_month, span.start_year)) begin
      tally.status = 1'b1;
      return tally;
    end
    d = span.start_day;
    m = span.start_month;
    y = span.start_year;
    wd = weekday_of(y, m, d);
    // The concatenation compares year, then month, then day.
    while (y <= YEAR_MAX && {y, m, d} < {span.end_year, span.end_month, span.end_day}) begin
      if (!weekend_mask_q[wd]) begin
        tally.working_days = tally.working_days + 22'd1;
      end
      if (d == month_length(m, y)) begin
        d = 5'd1;
        if (m == MON_DEC) begin
          m = 4'd1;
          y = y + 14'd1;
        end else begin
          m = m + 4'd1;
        end
      end else begin
        d = d + 5'd1;
      end
      wd = (wd + 1) % 7;
    end
    if (y > YEAR_MAX) begin
      y = YEAR_MAX;
      m = MON_DEC;
      d = 5'd31;
      wd = (wd + 6) % 7;
    end
    walk_day = d;
    walk_month = m;
    walk_year = y;
    walk_weekday = wd;
    return tally;
  endfunction

  always @(posedge clk) begin
    day_tally_t want;
    if (!rst_n) begin
      weekend_mask_q <= WEEKEND_RESET;
      walk_day = 5'd1;
      walk_month = 4'd1;
      walk_year = 14'd1;
      walk_weekday = 0;
      awaited_tallies.delete();
      awaited_count <= 0;
    end else begin
      if (cfg_we) begin
        weekend_mask_q <= cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        awaited_tallies.push_back(count_working_days(date_span_t'(in_tdata)));
      end
      if (out_tvalid && out_tready) begin
        if (awaited_tallies.size() == 0) begin
          $error("result item with no item waiting: working_days %0d, status %0d",
                 out_tdata[21:0], out_tuser[0]);
          fail_count = fail_count + 1;
        end else begin
          want = awaited_tallies.pop_front();
          if (out_tdata[21:0] !== want.working_days) begin
            $error("working_days: expected %0d, got %0d", want.working_days, out_tdata[21:0]);
            fail_count = fail_count + 1;
          end
          if (out_tuser[0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser[0]);
            fail_count = fail_count + 1;
          end
        end
      end
      awaited_count <= awaited_tallies.size();
    end
  end

endmodule

// ----- tb/working_day_counter_unit_test.sv -----
`timescale 1ns / 1ps
// Test top for the working-day counter: clock, reset, date items, weekend masks
// and output back-pressure. Depends on wdc_pkg and working_day_counter_checker.
module working_day_counter_unit_test;
  import wdc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  int          fail_count;
  int          awaited_count;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  logic        hold_off_go = 1'b0;
  int          hold_left = 0;
  longint      cycle_count = 0;
  longint      cycle_allowance = 0;

  working_day_counter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  working_day_counter_checker checker_inst (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a long hold-off once asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_off_go) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end
  end

  // The allowance grows with every item by the days it can step at most.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4 * cycle_allowance + 200000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint span_allowance(input logic [13:0] sy, input logic [13:0] ey);
    longint last;
    last = (ey > YEAR_MAX) ? YEAR_MAX : ey;
    return (last >= sy) ? (last - sy + 1) * 366 : 0;
  endfunction

  task automatic offer_dates(input logic [4:0] sd, input logic [3:0] sm, input logic [13:0] sy,
                             input logic [4:0] ed, input logic [3:0] em,
                             input logic [13:0] ey);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, ey, em, ed, sy, sm, sd};
    cycle_allowance = cycle_allowance + span_allowance(sy, ey) + 100;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly well-formed ranges of days to a few years; some long ranges, ranges
  // ending one day before, on or one day after the start, and broken start dates.
  task automatic offer_random_dates(input bit short_only);
    logic [4:0]  sd;
    logic [4:0]  ed;
    logic [3:0]  sm;
    logic [3:0]  em;
    logic [13:0] sy;
    logic [13:0] ey;
    int unsigned pick;
    int unsigned step;
    pick = short_only ? 0 : $urandom_range(99, 0);
    case ($urandom_range(9, 0))
      0:       sy = 14'($urandom_range(20, 1));
      1:       sy = 14'($urandom_range(9999, 9985));
      default: sy = 14'($urandom_range(9999, 1));
    endcase
    sm = 4'($urandom_range(12, 1));
    sd = ($urandom_range(4, 0) == 0) ? 5'($urandom_range(31, 28)) : 5'($urandom_range(28, 1));
    em = 4'($urandom_range(12, 1));
    ed = 5'($urandom_range(31, 1));
    ey = sy;
    if (short_only) begin
      em = sm + 4'($urandom_range(1, 0));
    end else if (pick < 70) begin
      step = $urandom_range(9, 0);
      ey = sy + ((step < 6) ? 14'd0 : (step < 9) ? 14'd1 : 14'($urandom_range(4, 2)));
      if (sy >= 9985 && $urandom_range(3, 0) == 0) begin
        ey = 14'($urandom_range(16383, 9999));
      end
      if ($urandom_range(9, 0) == 0) begin
        em = 4'($urandom_range(15, 0));
        ed = 5'($urandom_range(31, 0));
      end
    end else if (pick < 72) begin
      ey = sy + 14'($urandom_range(40, 5));
    end else if (pick < 85) begin
      // End one day before, on, or one day after the start.
      em = sm;
      ed = sd + 5'($urandom_range(2, 0)) - 5'd1;
    end else begin
      sd = 5'($urandom_range(31, 0));
      sm = 4'($urandom_range(15, 0));
      sy = 14'($urandom_range(16383, 0));
      ed = 5'($urandom_range(31, 0));
      em = 4'($urandom_range(15, 0));
      ey = 14'($urandom_range(16383, 0));
      case ($urandom_range(3, 0))
        0: sd = 5'd0;
        1: sm = ($urandom_range(3, 0) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
        2: sy = ($urandom_range(1, 0) == 0) ? 14'd0 : 14'($urandom_range(16383, 10000));
        default: begin
          sm = MON_FEB;
          sd = 5'($urandom_range(31, 30));
        end
      endcase
    end
    offer_dates(sd, sm, sy, ed, em, ey);
  endtask

  // The mask may only change with no item in flight.
  task automatic set_weekend_mask(input logic [6:0] mask);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    cfg_we <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset mask (Friday and Saturday off).
    offer_dates(1, 1, 2024, 8, 1, 2024);
    offer_dates(1, 1, 1, 1, 3, 1);
    offer_dates(28, 2, 2000, 2, 3, 2000);
    offer_dates(27, 2, 1900, 2, 3, 1900);
    offer_dates(30, 12, 2023, 3, 1, 2024);
    offer_dates(31, 1, 2024, 2, 2, 2024);
    offer_dates(20, 12, 9999, 31, 15, 16383);
    offer_dates(30, 12, 9999, 31, 12, 9999);
    offer_dates(29, 2, 2024, 29, 2, 2024);
    offer_dates(10, 3, 2024, 1, 3, 2024);
    offer_dates(10, 3, 2024, 31, 12, 2023);
    offer_dates(25, 12, 2024, 1, 13, 2024);
    offer_dates(10, 5, 2024, 0, 6, 2024);
    offer_dates(10, 5, 2024, 5, 0, 2025);
    offer_dates(15, 6, 1999, 15, 6, 2004);
    offer_dates(0, 1, 2024, 1, 2, 2024);
    offer_dates(31, 4, 2024, 1, 6, 2024);
    offer_dates(29, 2, 2023, 1, 4, 2023);
    offer_dates(1, 0, 2024, 1, 2, 2024);
    offer_dates(1, 13, 2024, 1, 2, 2025);
    offer_dates(1, 1, 0, 1, 1, 1);
    offer_dates(1, 1, 10000, 1, 1, 10001);
    offer_dates(31, 15, 16383, 31, 15, 16383);
    offer_dates(0, 0, 0, 0, 0, 0);

    set_weekend_mask(7'h00);
    repeat (180) offer_random_dates(1'b0);

    set_weekend_mask(7'h7f);
    sender_idle_pct = 77;
    repeat (120) offer_random_dates(1'b0);

    set_weekend_mask(7'h41);
    sender_idle_pct = 0;
    receiver_stall_pct = 77;
    repeat (200) offer_random_dates(1'b0);

    set_weekend_mask(7'($urandom_range(127, 0)));
    sender_idle_pct = 19;
    receiver_stall_pct = 19;
    repeat (200) offer_random_dates(1'b0);

    // Hold the receiver off while short items keep coming, so the block backs up.
    set_weekend_mask(WEEKEND_RESET);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_go <= 1'b1;
    @(posedge clk);
    hold_off_go <= 1'b0;
    repeat (40) offer_random_dates(1'b1);

    set_weekend_mask(7'($urandom_range(127, 0)));
    repeat (160) offer_random_dates(1'b0);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
